### hdl/csv_stream_parser_unit_assert.svh
// Assertion macros for the CSV stream parser.
// Used by csv_stream_parser_unit; no other dependencies.
`ifndef CSV_STREAM_PARSER_UNIT_ASSERT_SVH
`define CSV_STREAM_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define CSVP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvp assertion failed");
// Next-cycle implication, checked outside reset.
`define CSVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvp assertion failed");
`else
`define CSVP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CSVP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/csvp_pkg.sv
// Shared types and constants for the CSV stream parser.
// No dependencies; used by csvp_parse and csv_stream_parser_unit.
`default_nettype none

package csvp_pkg;

    // Characters with a fixed meaning in the text.
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Depth of the result queue and the most results one byte can cause.
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        MODE_ROW_START   = 3'd0,
        MODE_FIELD_START = 3'd1,
        MODE_UNQUOTED    = 3'd2,
        MODE_QUOTED      = 3'd3,
        MODE_QUOTE_SEEN  = 3'd4
    } mode_t;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        mode_t mode;
        logic  skip_lf;
    } parse_state_t;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       field_end;
        logic       row_end;
        logic       last_result;
    } out_item_t;

endpackage

`default_nettype wire

### hdl/csvp_parse.sv
// Combinational CSV parse step: one byte and the current state in, up to two results out.
// Depends on csvp_pkg.
`default_nettype none

module csvp_parse (
    input  wire logic [7:0]            delimiter,
    input  wire csvp_pkg::in_item_t    item,
    input  wire csvp_pkg::parse_state_t state,
    output csvp_pkg::parse_state_t     state_next,
    output logic [1:0]                 res_count,
    output csvp_pkg::out_item_t        res0,
    output csvp_pkg::out_item_t        res1
);
    import csvp_pkg::*;

    logic      is_delim;
    logic      is_quote;
    logic      is_cr;
    logic      is_lf;
    logic      is_term;
    logic      swallow;
    out_item_t byte_res;
    out_item_t term_res;
    out_item_t end_res;
    mode_t     term_mode;

    // Byte classification; the delimiter wins over CR and LF.
    assign is_delim = (item.data_byte == delimiter);
    assign is_quote = (item.data_byte == CH_QUOTE);
    assign is_cr    = (item.data_byte == CH_CR);
    assign is_lf    = (item.data_byte == CH_LF);
    assign is_term  = is_delim || is_cr || is_lf;
    assign swallow  = state.skip_lf && is_lf;

    // Prebuilt result shapes.
    always_comb
    begin
        byte_res           = '0;
        byte_res.has_byte  = 1'b1;
        byte_res.out_byte  = item.data_byte;
        term_res           = '0;
        term_res.field_end = 1'b1;
        term_res.row_end   = !is_delim;
        end_res            = '0;
        end_res.field_end  = 1'b1;
        end_res.row_end    = 1'b1;
        term_mode          = is_delim ? MODE_FIELD_START : MODE_ROW_START;
    end

    // Mode transitions and result generation for one byte.
    always_comb
    begin
        res_count          = 2'd0;
        res0               = '0;
        res1               = '0;
        state_next.mode    = state.mode;
        state_next.skip_lf = 1'b0;

        if (!swallow)
        begin
            case (state.mode)
                MODE_UNQUOTED:
                begin
                    res_count = 2'd1;
                    if (is_term)
                    begin
                        res0               = term_res;
                        state_next.mode    = term_mode;
                        state_next.skip_lf = !is_delim && is_cr;
                    end
                    else
                    begin
                        res0 = byte_res;
                    end
                end
                MODE_QUOTED:
                begin
                    if (is_quote)
                    begin
                        state_next.mode = MODE_QUOTE_SEEN;
                    end
                    else
                    begin
                        res0      = byte_res;
                        res_count = 2'd1;
                    end
                end
                MODE_QUOTE_SEEN:
                begin
                    if (is_quote)
                    begin
                        // A doubled quote is one literal quote.
                        res0            = byte_res;
                        res_count       = 2'd1;
                        state_next.mode = MODE_QUOTED;
                    end
                    else if (is_term)
                    begin
                        res0               = term_res;
                        res_count          = 2'd1;
                        state_next.mode    = term_mode;
                        state_next.skip_lf = !is_delim && is_cr;
                    end
                    else
                    begin
                        // Stray byte: close the quoted field, then open an unquoted one.
                        res0            = '0;
                        res0.field_end  = 1'b1;
                        res1            = byte_res;
                        res_count       = 2'd2;
                        state_next.mode = MODE_UNQUOTED;
                    end
                end
                default:
                begin
                    if (is_quote)
                    begin
                        state_next.mode = MODE_QUOTED;
                    end
                    else if (is_term)
                    begin
                        res0               = term_res;
                        res_count          = 2'd1;
                        state_next.mode    = term_mode;
                        state_next.skip_lf = !is_delim && is_cr;
                    end
                    else
                    begin
                        res0            = byte_res;
                        res_count       = 2'd1;
                        state_next.mode = MODE_UNQUOTED;
                    end
                end
            endcase
        end

        // End of input closes any open field and row.
        if (item.end_of_input)
        begin
            if (state_next.mode != MODE_ROW_START)
            begin
                if (res_count == 2'd2)
                begin
                    res1.field_end = 1'b1;
                    res1.row_end   = 1'b1;
                end
                else if (res_count == 2'd1 && !res0.field_end)
                begin
                    res0.field_end = 1'b1;
                    res0.row_end   = 1'b1;
                end
                else if (res_count == 2'd1)
                begin
                    res1      = end_res;
                    res_count = 2'd2;
                end
                else
                begin
                    res0      = end_res;
                    res_count = 2'd1;
                end
            end
            state_next.mode    = MODE_ROW_START;
            state_next.skip_lf = 1'b0;
        end

        // Flag the final result of this byte.
        if (res_count == 2'd2)
        begin
            res1.last_result = 1'b1;
        end
        else if (res_count == 2'd1)
        begin
            res0.last_result = 1'b1;
        end
    end

endmodule

`default_nettype wire

### hdl/csv_stream_parser_unit.sv
// CSV stream parser top level: input register, parse step, two-entry result queue.
// Depends on csvp_pkg, csvp_parse and csv_stream_parser_unit_assert.svh.
//
// Usage:
// The byte channel (byte_valid, byte_stall, byte_item) carries one text byte
// per transfer together with an end-of-input flag. The token channel
// (tok_valid, tok_stall, tok_item) carries results: a content byte and/or
// field-end and row-end marks, with last_result on the final result of a byte.
// A byte causes zero, one or two results. The delimiter is written through
// cfg_we/cfg_wdata, by the user only while the block is idle, a rule that the
// block leaves unchecked; it resets to a comma. A taken byte is held in the
// input register and parsed there; its results enter the queue once they fit.
// Throughput: one byte per cycle while each byte causes at most one result
// and tok_stall is low. Whether results fit is judged before this cycle's pop,
// so a byte with two results waits in the input register until the queue is
// empty, and the byte behind it waits until an entry is free. The queue depth
// sets these limits.
// Reset clears the parse state, the queue and the input register; no result
// is lost when tok_stall is held: the queue fills, then byte_stall rises.
`default_nettype none
`include "csv_stream_parser_unit_assert.svh"

module csv_stream_parser_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_wdata,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire csvp_pkg::in_item_t byte_item,
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output csvp_pkg::out_item_t     tok_item
);
    import csvp_pkg::*;

    logic [7:0]   delim_reg;
    logic         in_valid_reg;
    logic         in_valid_next;
    in_item_t     in_item_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    out_item_t    queue_reg [QUEUE_DEPTH];
    out_item_t    queue_next [QUEUE_DEPTH];
    logic [1:0]   res_count;
    out_item_t    res0;
    out_item_t    res1;
    logic [1:0]   space;
    logic [1:0]   count_left;
    logic         fits;
    logic         consume;
    logic         pop;
    logic         accept;

    // Parse step on the registered byte.
    csvp_parse u_parse (
        .delimiter  (delim_reg),
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res_count  (res_count),
        .res0       (res0),
        .res1       (res1)
    );

    // Handshake decisions.
    assign space      = 2'(QUEUE_DEPTH) - count_reg;
    assign fits       = (res_count <= space);
    assign consume    = in_valid_reg && fits;
    assign byte_stall = in_valid_reg && !fits;
    assign accept     = byte_valid && !byte_stall;
    assign tok_valid  = (count_reg != 2'd0);
    assign tok_item   = queue_reg[0];
    assign pop        = tok_valid && !tok_stall;
    assign count_left = count_reg - {1'b0, pop};

    // Input register occupancy.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Result queue: pop from the head, then append new results.
    always_comb
    begin
        queue_next[0] = pop ? queue_reg[1] : queue_reg[0];
        queue_next[1] = queue_reg[1];
        count_next    = count_left;
        if (consume && res_count != 2'd0)
        begin
            count_next = count_left + res_count;
            if (count_left == 2'd0)
            begin
                queue_next[0] = res0;
                queue_next[1] = res1;
            end
            else
            begin
                queue_next[1] = res0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg     <= CH_COMMA;
            in_valid_reg  <= 1'b0;
            state_reg     <= '{mode: MODE_ROW_START, skip_lf: 1'b0};
            count_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                delim_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
            if (consume)
            begin
                state_reg <= state_next;
            end
            count_reg <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= byte_item;
        end
        queue_reg[0] <= queue_next[0];
        queue_reg[1] <= queue_next[1];
    end

    // Checks on the queue and the parse state.
    `CSVP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= 2'(QUEUE_DEPTH))
    `CSVP_ASSERT_NOW(a_skip_at_row_start, clk, rst_n, state_reg.skip_lf,
        state_reg.mode == MODE_ROW_START)
    `CSVP_ASSERT_NEXT(a_eof_resets, clk, rst_n, consume && in_item_reg.end_of_input,
        state_reg.mode == MODE_ROW_START && !state_reg.skip_lf)
    `CSVP_ASSERT_NOW(a_row_has_field, clk, rst_n, tok_valid && tok_item.row_end,
        tok_item.field_end)

endmodule

`default_nettype wire

### sim/tb_csv_stream_parser_unit.sv
// Testbench for csv_stream_parser_unit: directed and random CSV texts checked against a
// behavioral parser held in the bench. Depends on csvp_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_csv_stream_parser_unit;

    import csvp_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       byte_valid;
    logic       byte_stall;
    in_item_t   byte_item;
    logic       tok_valid;
    logic       tok_stall;
    out_item_t  tok_item;

    // Tokens still owed by the unit, oldest first.
    out_item_t  token_expect[$];

    // Parser state as the bench sees it.
    mode_t      parse_mode_m;
    logic       lf_pending;
    logic [7:0] delim_m;
    out_item_t  step_tokens[0:3];
    int         step_count;

    int         errors;
    int         bytes_sent;
    int         burst_left;
    bit         sender_gaps;
    logic [7:0] text_buf[$];

    // Receiver state: long hold-offs are ordered by the stimulus side.
    int         hold_orders;
    int         holds_done;
    int         hold_count;
    int         stall_pct;
    int         pattern_left;

    csv_stream_parser_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_item   (tok_item)
    );

    // 8 ns clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------
    // Behavioral parser
    // ---------------------------------------------------------------

    // Appends one token to the tokens of the current byte.
    function automatic void add_token(input logic has, input logic [7:0] b,
                                      input logic fe, input logic re);
        out_item_t t;
        t.has_byte    = has;
        t.out_byte    = has ? b : 8'h00;
        t.field_end   = fe;
        t.row_end     = re;
        t.last_result = 1'b0;
        step_tokens[step_count] = t;
        step_count++;
    endfunction

    // Delimiter, CR and LF close the field; returns 1 if the byte was one of them.
    function automatic bit close_on_break(input logic [7:0] b);
        if (b == delim_m)
        begin
            add_token(1'b0, 8'h00, 1'b1, 1'b0);
            parse_mode_m = MODE_FIELD_START;
            return 1'b1;
        end
        if (b == CH_CR)
        begin
            add_token(1'b0, 8'h00, 1'b1, 1'b1);
            parse_mode_m = MODE_ROW_START;
            lf_pending = 1'b1;
            return 1'b1;
        end
        if (b == CH_LF)
        begin
            add_token(1'b0, 8'h00, 1'b1, 1'b1);
            parse_mode_m = MODE_ROW_START;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // First byte of a field: a quote opens quoted mode before any break test.
    function automatic void open_field(input logic [7:0] b);
        if (b == CH_QUOTE)
            parse_mode_m = MODE_QUOTED;
        else if (!close_on_break(b))
        begin
            add_token(1'b1, b, 1'b0, 1'b0);
            parse_mode_m = MODE_UNQUOTED;
        end
    endfunction

    // Works out the tokens of one accepted byte and queues them.
    function automatic void predict_tokens(input logic [7:0] b, input logic eof);
        logic swallow;
        swallow = 1'b0;
        step_count = 0;
        if (lf_pending)
        begin
            lf_pending = 1'b0;
            swallow = (b == CH_LF);
        end
        if (!swallow)
        begin
            case (parse_mode_m)
                MODE_UNQUOTED:
                    if (!close_on_break(b))
                        add_token(1'b1, b, 1'b0, 1'b0);
                MODE_QUOTED:
                    if (b == CH_QUOTE)
                        parse_mode_m = MODE_QUOTE_SEEN;
                    else
                        add_token(1'b1, b, 1'b0, 1'b0);
                MODE_QUOTE_SEEN:
                    if (b == CH_QUOTE)
                    begin
                        add_token(1'b1, CH_QUOTE, 1'b0, 1'b0);
                        parse_mode_m = MODE_QUOTED;
                    end
                    else if (!close_on_break(b))
                    begin
                        // Stray byte after a closing quote starts a new field.
                        add_token(1'b0, 8'h00, 1'b1, 1'b0);
                        open_field(b);
                    end
                default:
                    open_field(b);
            endcase
        end
        // End of text closes any open field and row.
        if (eof)
        begin
            if (parse_mode_m != MODE_ROW_START)
            begin
                if (step_count > 0 && !step_tokens[step_count - 1].field_end)
                begin
                    step_tokens[step_count - 1].field_end = 1'b1;
                    step_tokens[step_count - 1].row_end   = 1'b1;
                end
                else
                    add_token(1'b0, 8'h00, 1'b1, 1'b1);
            end
            parse_mode_m = MODE_ROW_START;
            lf_pending = 1'b0;
        end
        if (step_count > 0)
            step_tokens[step_count - 1].last_result = 1'b1;
        for (int i = 0; i < step_count; i++)
            token_expect.push_back(step_tokens[i]);
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Each token transfer is compared with the oldest expected token.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n === 1'b1 && tok_valid === 1'b1 && tok_stall === 1'b0)
        begin
            if (token_expect.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected token: expected none, got %h", $time, tok_item);
            end
            else
            begin
                want = token_expect.pop_front();
                check_field("has_byte", 8'(want.has_byte), 8'(tok_item.has_byte));
                check_field("out_byte", want.out_byte, tok_item.out_byte);
                check_field("field_end", 8'(want.field_end), 8'(tok_item.field_end));
                check_field("row_end", 8'(want.row_end), 8'(tok_item.row_end));
                check_field("last_result", 8'(want.last_result),
                            8'(tok_item.last_result));
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall rate changes in stretches; long hold-offs on request.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_count > 0)
        begin
            hold_count--;
            tok_stall <= 1'b1;
        end
        else if (holds_done != hold_orders)
        begin
            holds_done++;
            hold_count = 300;
            tok_stall <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            tok_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Offers one byte and waits for its transfer; gaps fall between bursts.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_valid <= 1'b1;
        byte_item  <= {b, eof};
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        predict_tokens(b, eof);
        bytes_sent++;
    endtask

    task automatic send_string(input string s, input bit eof_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eof_last && (i == s.len() - 1));
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Stops offering and waits until every expected token has arrived.
    task automatic drain_tokens();
        byte_valid <= 1'b0;
        burst_left = 0;
        while (token_expect.size() != 0) @(posedge clk);
        // A byte with no tokens may still be in flight.
        repeat (6) @(posedge clk);
    endtask

    task automatic set_delimiter(input logic [7:0] d);
        drain_tokens();
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        delim_m = d;
    endtask

    // Random byte that has no special meaning under the current delimiter.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == delim_m || b == CH_QUOTE || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    // Builds a mostly well-formed text of at least n bytes into text_buf.
    task automatic build_text(input int n);
        int         len;
        logic [7:0] b;
        text_buf.delete();
        while (text_buf.size() < n)
        begin
            len = $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    repeat (len) text_buf.push_back(plain_byte());
                5, 6, 7, 8:
                begin
                    text_buf.push_back(CH_QUOTE);
                    repeat (len)
                    begin
                        case ($urandom_range(0, 9))
                            0: text_buf.push_back(delim_m);
                            1: text_buf.push_back(CH_CR);
                            2: text_buf.push_back(CH_LF);
                            3:
                            begin
                                text_buf.push_back(CH_QUOTE);
                                text_buf.push_back(CH_QUOTE);
                            end
                            default: text_buf.push_back(plain_byte());
                        endcase
                    end
                    if ($urandom_range(0, 7) != 0)
                        text_buf.push_back(CH_QUOTE);
                    if ($urandom_range(0, 7) == 0)
                        text_buf.push_back(plain_byte());
                end
                default:
                    // Broken field: arbitrary bytes.
                    repeat (len + 1)
                    begin
                        b = 8'($urandom_range(0, 255));
                        text_buf.push_back(b);
                    end
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: text_buf.push_back(delim_m);
                6: text_buf.push_back(CH_CR);
                7: text_buf.push_back(CH_LF);
                8:
                begin
                    text_buf.push_back(CH_CR);
                    text_buf.push_back(CH_LF);
                end
                default: ;
            endcase
        end
    endtask

    function automatic logic [7:0] delim_choice(input int k);
        case (k)
            0: return 8'h00;
            1: return 8'hFF;
            2: return CH_LF;
            3: return CH_QUOTE;
            4: return CH_CR;
            default: return 8'h3B;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Quoting, stray bytes, end-of-text cases and extreme byte values.
    task automatic test_quoting_rules();
        // Doubled quote, breaks as data, stray byte, empty field, CR LF.
        send_string("\"q\"\"\015,\n\"s,\015\n", 1'b0);
        // Zero byte and 0xFF as data; trailing delimiter at the end.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_COMMA, 1'b1);
        // Unterminated quoted field.
        send_string("\"x", 1'b1);
        // Swallowed LF as the last byte.
        send_string("\015\n", 1'b1);
        // Empty quoted field closed by the end.
        send_string("\"\"", 1'b1);
        // Line break at the end.
        send_string("\n", 1'b1);
        // Unquoted field closed by the end.
        send_string("ab", 1'b1);
        drain_tokens();
    endtask

    // Delimiter extremes and delimiters that collide with quote, CR and LF.
    task automatic test_delimiter_choices();
        for (int k = 0; k < 6; k++)
        begin
            set_delimiter(delim_choice(k));
            send_string("\015\n", 1'b0);
            send_byte(delim_m, 1'b0);
            send_byte(CH_QUOTE, 1'b0);
            build_text($urandom_range(20, 40));
            send_text();
        end
        set_delimiter(CH_COMMA);
    endtask

    // Receiver holds off for a long stretch while bytes keep coming.
    task automatic test_long_hold();
        sender_gaps = 1'b0;
        hold_orders <= hold_orders + 1;
        build_text(80);
        send_text();
        sender_gaps = 1'b1;
        drain_tokens();
    endtask

    // Random texts, with occasional noise and delimiter changes.
    task automatic test_random_texts(input int target);
        int text_count;
        int n;
        text_count = 0;
        while (bytes_sent < target)
        begin
            text_count++;
            sender_gaps = ($urandom_range(0, 3) != 0);
            if (text_count % 12 == 0)
                set_delimiter(($urandom_range(0, 2) == 0) ? CH_COMMA
                                                          : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
            begin
                // Noise: arbitrary bytes with arbitrary end flags.
                n = $urandom_range(5, 30);
                repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            else
            begin
                build_text($urandom_range(4, 40));
                send_text();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= 8'h00;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        tok_stall  <= 1'b0;
        delim_m      = CH_COMMA;
        parse_mode_m = MODE_ROW_START;
        lf_pending   = 1'b0;
        errors       = 0;
        bytes_sent   = 0;
        burst_left   = 0;
        sender_gaps  = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_quoting_rules();
        test_delimiter_choices();
        test_long_hold();
        test_random_texts(1300);
        drain_tokens();

        if (errors == 0 && token_expect.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
